// ----- hw/rtl/esfp_pkg.sv -----
// Shared types and constants for the encoder state-feedback motor PWM core.
// No dependencies; imported by every module of the block.
package esfp_pkg;

  localparam int REG_W     = 32;
  localparam int PROD_W    = 2 * REG_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0] TARGET_RST   = 32'd1820;
  localparam logic [REG_W-1:0] GAIN_REF_RST = 32'd65536;
  localparam logic [REG_W-1:0] GAIN_POS_RST = 32'd65536;
  localparam logic [REG_W-1:0] GAIN_VEL_RST = 32'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET   = 2'd0,
    REG_GAIN_REF = 2'd1,
    REG_GAIN_POS = 2'd2,
    REG_GAIN_VEL = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    FUNC_EDGE = 1'b0,
    FUNC_TICK = 1'b1
  } func_t;

  typedef struct packed {
    logic signed [REG_W-1:0] target;
    logic signed [REG_W-1:0] gain_ref;
    logic signed [REG_W-1:0] gain_pos;
    logic signed [REG_W-1:0] gain_vel;
  } cfg_t;

  typedef struct packed {
    logic signed [REG_W-1:0] count;
    logic signed [REG_W-1:0] delta;
  } opnd_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] t_ref;
    logic signed [PROD_W-1:0] t_pos;
    logic signed [PROD_W-1:0] t_vel;
  } prod_t;

  typedef struct packed {
    logic s0;
    logic prod;
    logic out;
  } adv_t;

endpackage

// ----- hw/rtl/esfp_enc.sv -----
// Encoder position counter and tick operand capture stage.
// Depends on esfp_pkg.
module esfp_enc (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            func,
  input  logic            enc_b,
  input  logic            adv,
  output logic            s0_valid,
  output esfp_pkg::opnd_t opnd
);
  import esfp_pkg::*;

  logic [REG_W-1:0] count_r;
  logic [REG_W-1:0] last_r;
  logic             s0_valid_r;
  opnd_t            opnd_r;
  logic             is_tick;

  assign is_tick  = (func_t'(func) == FUNC_TICK);
  assign s0_valid = s0_valid_r;
  assign opnd     = opnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      last_r     <= '0;
      s0_valid_r <= 1'b0;
    end else begin
      if (accept && !is_tick) begin
        count_r <= enc_b ? count_r + REG_W'(1) : count_r - REG_W'(1);
      end
      if (accept && is_tick) begin
        last_r <= count_r;
      end
      if (adv) begin
        s0_valid_r <= accept && is_tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_tick) begin
      opnd_r.count <= signed'(count_r);
      opnd_r.delta <= signed'(count_r - last_r);
    end
  end

endmodule

// ----- hw/rtl/esfp_mul.sv -----
// Multiply stage: three signed 32x32 products into a product register.
// Depends on esfp_pkg.
module esfp_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s0_valid,
  input  esfp_pkg::opnd_t opnd,
  input  esfp_pkg::cfg_t  cfg,
  input  logic            adv,
  output logic            p_valid,
  output esfp_pkg::prod_t prod
);
  import esfp_pkg::*;

  logic  p_valid_r;
  prod_t prod_r;
  prod_t prod_nxt;

  assign p_valid = p_valid_r;
  assign prod    = prod_r;

  always_comb begin
    prod_nxt.t_ref = cfg.gain_ref * cfg.target;
    prod_nxt.t_pos = cfg.gain_pos * opnd.count;
    prod_nxt.t_vel = cfg.gain_vel * opnd.delta;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s0_valid) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- hw/rtl/esfp_sat.sv -----
// Sum, scale and saturate stage with the result register.
// Depends on esfp_pkg.
module esfp_sat #(
  parameter int DUTY_BITS  = 13,
  parameter int GAIN_SHIFT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 p_valid,
  input  esfp_pkg::prod_t      prod,
  input  logic                 adv,
  output logic                 out_valid,
  output logic                 out_reverse,
  output logic [DUTY_BITS-1:0] out_duty,
  output logic                 out_saturated
);
  import esfp_pkg::*;

  localparam logic signed [SUM_W-1:0] LIM     = signed'(SUM_W'((1 << DUTY_BITS) - 1));
  localparam logic signed [SUM_W-1:0] NEG_LIM = -LIM;
  localparam int                      EXT_W   = SUM_W - PROD_W;

  logic signed [SUM_W-1:0] a_ext, b_ext, c_ext;
  logic signed [SUM_W-1:0] sum_s, u_s, u_abs;
  logic                    hi, lo;
  logic                    valid_r, reverse_r, sat_r;
  logic                    reverse_nxt, sat_nxt;
  logic [DUTY_BITS-1:0]    duty_r, duty_nxt;

  always_comb begin
    a_ext = signed'({{EXT_W{prod.t_ref[PROD_W-1]}}, prod.t_ref});
    b_ext = signed'({{EXT_W{prod.t_pos[PROD_W-1]}}, prod.t_pos});
    c_ext = signed'({{EXT_W{prod.t_vel[PROD_W-1]}}, prod.t_vel});
    sum_s = a_ext - b_ext - c_ext;
    // Arithmetic shift of the exact sum is the floor of the scaled value.
    u_s   = sum_s >>> GAIN_SHIFT;
    hi    = (u_s > LIM);
    lo    = (u_s < NEG_LIM);
    u_abs = u_s[SUM_W-1] ? -u_s : u_s;
    reverse_nxt = u_s[SUM_W-1];
    sat_nxt     = hi || lo;
    duty_nxt    = sat_nxt ? LIM[DUTY_BITS-1:0] : u_abs[DUTY_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p_valid) begin
      reverse_r <= reverse_nxt;
      sat_r     <= sat_nxt;
      duty_r    <= duty_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_reverse   = reverse_r;
  assign out_saturated = sat_r;
  assign out_duty      = duty_r;

endmodule

// ----- hw/rtl/encoder_state_feedback_motor_pwm_core.sv -----
// Top level of the encoder state-feedback motor PWM core.
// Depends on esfp_pkg, esfp_enc, esfp_mul and esfp_sat.
//
// Usage: while in_ready is high, the core takes one beat per cycle on the input
// channel. An encoder beat (func 0) moves the 32-bit position count up when
// enc_b is high and down when it is low, wrapping, and yields no result beat.
// A tick beat (func 1) forms u = floor((gain_ref*target - gain_pos*count
// - gain_vel*delta) / 2^GAIN_SHIFT), with delta the count change since the
// previous tick, and yields one result beat: direction, duty clamped to
// 2^DUTY_BITS-1, and a saturation flag. Throughput is one beat per cycle while
// in_ready is high; a tick's result is registered in operand capture, the three
// parallel 32x32 multipliers, and the 66-bit sum-and-clamp stage, in order.
// Stages collapse bubbles, so up to three tick results can be held while the
// output is stalled before in_ready drops. Write configuration only while
// the core is idle; registers take effect on the next tick.
module encoder_state_feedback_motor_pwm_core #(
  parameter int DUTY_BITS  = 13,
  parameter int GAIN_SHIFT = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [esfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esfp_pkg::REG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic                           in_enc_b,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_reverse,
  output logic [DUTY_BITS-1:0]           out_duty,
  output logic                           out_saturated
);
  import esfp_pkg::*;

  cfg_t  cfg_r;
  opnd_t opnd;
  prod_t prod;
  adv_t  adv;
  logic  s0_valid, p_valid, in_accept;

  // Configuration register file; writes land directly, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target   <= signed'(TARGET_RST);
      cfg_r.gain_ref <= signed'(GAIN_REF_RST);
      cfg_r.gain_pos <= signed'(GAIN_POS_RST);
      cfg_r.gain_vel <= signed'(GAIN_VEL_RST);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_TARGET:   cfg_r.target   <= signed'(cfg_wdata);
        REG_GAIN_REF: cfg_r.gain_ref <= signed'(cfg_wdata);
        REG_GAIN_POS: cfg_r.gain_pos <= signed'(cfg_wdata);
        REG_GAIN_VEL: cfg_r.gain_vel <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Advance each stage when the one downstream has room or is draining.
  always_comb begin
    adv.out  = !out_valid || out_ready;
    adv.prod = !p_valid || adv.out;
    adv.s0   = !s0_valid || adv.prod;
  end

  assign in_ready  = adv.s0;
  assign in_accept = in_valid && in_ready;

  esfp_enc u_enc (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .func     (in_func),
    .enc_b    (in_enc_b),
    .adv      (adv.s0),
    .s0_valid (s0_valid),
    .opnd     (opnd)
  );

  esfp_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .s0_valid (s0_valid),
    .opnd     (opnd),
    .cfg      (cfg_r),
    .adv      (adv.prod),
    .p_valid  (p_valid),
    .prod     (prod)
  );

  esfp_sat #(
    .DUTY_BITS  (DUTY_BITS),
    .GAIN_SHIFT (GAIN_SHIFT)
  ) u_sat (
    .clk           (clk),
    .rst_n         (rst_n),
    .p_valid       (p_valid),
    .prod          (prod),
    .adv           (adv.out),
    .out_valid     (out_valid),
    .out_reverse   (out_reverse),
    .out_duty      (out_duty),
    .out_saturated (out_saturated)
  );

endmodule

// ----- hw/rtl/esfp_chk.sv -----
// Port-level checker for the encoder state-feedback motor PWM core, with bind.
// Depends on esfp_pkg and encoder_state_feedback_motor_pwm_core.
module esfp_chk #(
  parameter int DUTY_BITS = 13
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic [esfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [esfp_pkg::REG_W-1:0]     cfg_wdata,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_func,
  input logic                           in_enc_b,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_reverse,
  input logic [DUTY_BITS-1:0]           out_duty,
  input logic                           out_saturated
);
  import esfp_pkg::*;

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty)
      && $stable(out_reverse) && $stable(out_saturated))
    else $error("result beat changed while stalled");

  // A clamped result drives full scale.
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> (&out_duty))
    else $error("saturated result not at full scale");

  // Zero duty is always forward.
  a_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_duty == '0) |-> !out_reverse)
    else $error("zero duty flagged reverse");

  // Input backpressure only when results are piled up at the output.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with output free");

  // Reset empties the result register.
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind encoder_state_feedback_motor_pwm_core esfp_chk #(.DUTY_BITS(DUTY_BITS)) u_chk (.*);
